/* rtl/core/tle_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tle_pkg: shared types and constants for the terminal line editor
// Key codes, sizes, and the command/status bundles passed between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tle_pkg;

    localparam int LINE_CAP = 63;
    localparam int LEN_W    = $clog2(LINE_CAP + 1);
    localparam int ADDR_W   = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;
    localparam int CHAR_W   = 8;
    localparam int CFG_W    = 6;

    localparam logic [CFG_W-1:0] MAX_LEN_RESET = 6'd63;

    localparam logic [CHAR_W-1:0] KEY_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] KEY_DELETE    = 8'h7F;
    localparam logic [CHAR_W-1:0] KEY_ESCAPE    = 8'h1B;
    localparam logic [CHAR_W-1:0] KEY_BRACKET   = 8'h5B;
    localparam logic [CHAR_W-1:0] KEY_LEFT      = 8'h44;
    localparam logic [CHAR_W-1:0] KEY_RIGHT     = 8'h43;
    localparam logic [CHAR_W-1:0] KEY_HOME      = 8'h01;
    localparam logic [CHAR_W-1:0] KEY_BACK      = 8'h02;
    localparam logic [CHAR_W-1:0] KEY_END       = 8'h05;
    localparam logic [CHAR_W-1:0] KEY_FORWARD   = 8'h06;
    localparam logic [CHAR_W-1:0] KEY_PRINT_LOW = 8'h20;

    typedef enum logic [1:0] {
        PHASE_NORMAL,
        PHASE_ESC,
        PHASE_BRACKET
    } phase_t;

    typedef enum logic [3:0] {
        KIND_RETURN,
        KIND_DELETE,
        KIND_ESCAPE,
        KIND_HOME,
        KIND_BACK,
        KIND_END,
        KIND_FORWARD,
        KIND_PRINT,
        KIND_OTHER
    } kind_t;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_ZERO,
        CUR_DEC,
        CUR_INC,
        CUR_END
    } cur_op_t;

    typedef enum logic [1:0] {
        LEN_HOLD,
        LEN_ZERO,
        LEN_INC,
        LEN_DEC
    } len_op_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_LEN,
        IDX_CUR,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_PREV,
        RD_IDX
    } rd_op_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_SHIFT_UP,
        WR_SHIFT_DOWN,
        WR_BYTE
    } wr_op_t;

    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_CHAR,
        OUT_EMPTY
    } out_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_INS_RD,
        ST_INS_WR,
        ST_DEL_RD,
        ST_DEL_WR,
        ST_RET_EMPTY,
        ST_RET_RD,
        ST_RET_LOAD
    } state_t;

    typedef struct packed {
        logic    load_byte;
        logic    phase_wr;
        phase_t  phase_val;
        cur_op_t cur_op;
        len_op_t len_op;
        idx_op_t idx_op;
        rd_op_t  rd_op;
        wr_op_t  wr_op;
        out_op_t out_op;
    } cmd_t;

    typedef struct packed {
        phase_t phase;
        kind_t  kind;
        logic   is_bracket;
        logic   is_left;
        logic   is_right;
        logic   cur_gt0;
        logic   cur_lt_len;
        logic   len_lt_max;
        logic   len_zero;
        logic   idx_gt_cur;
        logic   idx_lt_len;
        logic   idx_last;
        logic   out_free;
    } status_t;

endpackage

`default_nettype wire

/* rtl/core/tle_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tle_ctrl: line editor controller
// Decodes each request and sequences buffer shifts and line readout.
// ----------------------------------------------------------------------------
`default_nettype none

module tle_ctrl
    import tle_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DECODE;
            end
            ST_DECODE: begin
                state_next = ST_IDLE;
                if (status.phase == PHASE_NORMAL) begin
                    case (status.kind)
                        KIND_RETURN: begin
                            state_next = status.len_zero ? ST_RET_EMPTY : ST_RET_RD;
                        end
                        KIND_DELETE: begin
                            if (status.cur_gt0) state_next = ST_DEL_RD;
                        end
                        KIND_PRINT: begin
                            if (status.len_lt_max) state_next = ST_INS_RD;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INS_RD: state_next = status.idx_gt_cur ? ST_INS_WR : ST_IDLE;
            ST_INS_WR: state_next = ST_INS_RD;
            ST_DEL_RD: state_next = status.idx_lt_len ? ST_DEL_WR : ST_IDLE;
            ST_DEL_WR: state_next = ST_DEL_RD;
            ST_RET_EMPTY: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            ST_RET_RD: state_next = ST_RET_LOAD;
            ST_RET_LOAD: begin
                if (status.out_free) begin
                    state_next = status.idx_last ? ST_IDLE : ST_RET_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd           = '0;
        cmd.phase_val = PHASE_NORMAL;
        cmd.cur_op    = CUR_HOLD;
        cmd.len_op    = LEN_HOLD;
        cmd.idx_op    = IDX_HOLD;
        cmd.rd_op     = RD_NONE;
        cmd.wr_op     = WR_NONE;
        cmd.out_op    = OUT_NONE;
        s_tready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready      = 1'b1;
                cmd.load_byte = s_tvalid;
            end
            ST_DECODE: begin
                unique case (status.phase)
                    PHASE_ESC: begin
                        cmd.phase_wr  = 1'b1;
                        cmd.phase_val = status.is_bracket ? PHASE_BRACKET : PHASE_NORMAL;
                    end
                    PHASE_NORMAL: begin
                        case (status.kind)
                            KIND_RETURN: begin
                                if (!status.len_zero) cmd.idx_op = IDX_ZERO;
                            end
                            KIND_DELETE: begin
                                if (status.cur_gt0) cmd.idx_op = IDX_CUR;
                            end
                            KIND_ESCAPE: begin
                                cmd.phase_wr  = 1'b1;
                                cmd.phase_val = PHASE_ESC;
                            end
                            KIND_HOME: cmd.cur_op = CUR_ZERO;
                            KIND_BACK: begin
                                if (status.cur_gt0) cmd.cur_op = CUR_DEC;
                            end
                            KIND_END: cmd.cur_op = CUR_END;
                            KIND_FORWARD: begin
                                if (status.cur_lt_len) cmd.cur_op = CUR_INC;
                            end
                            KIND_PRINT: begin
                                if (status.len_lt_max) cmd.idx_op = IDX_LEN;
                            end
                            default: cmd.cur_op = CUR_HOLD;
                        endcase
                    end
                    default: begin
                        // direction byte after ESC [
                        cmd.phase_wr = 1'b1;
                        if (status.is_left && status.cur_gt0) begin
                            cmd.cur_op = CUR_DEC;
                        end else if (status.is_right && status.cur_lt_len) begin
                            cmd.cur_op = CUR_INC;
                        end
                    end
                endcase
            end
            ST_INS_RD: begin
                if (status.idx_gt_cur) begin
                    cmd.rd_op = RD_PREV;
                end else begin
                    cmd.wr_op  = WR_BYTE;
                    cmd.len_op = LEN_INC;
                    cmd.cur_op = CUR_INC;
                end
            end
            ST_INS_WR: begin
                cmd.wr_op  = WR_SHIFT_UP;
                cmd.idx_op = IDX_DEC;
            end
            ST_DEL_RD: begin
                if (status.idx_lt_len) begin
                    cmd.rd_op = RD_IDX;
                end else begin
                    cmd.len_op = LEN_DEC;
                    cmd.cur_op = CUR_DEC;
                end
            end
            ST_DEL_WR: begin
                cmd.wr_op  = WR_SHIFT_DOWN;
                cmd.idx_op = IDX_INC;
            end
            ST_RET_EMPTY: begin
                if (status.out_free) begin
                    cmd.out_op   = OUT_EMPTY;
                    cmd.cur_op   = CUR_ZERO;
                    cmd.len_op   = LEN_ZERO;
                    cmd.phase_wr = 1'b1;
                end
            end
            ST_RET_RD: cmd.rd_op = RD_IDX;
            ST_RET_LOAD: begin
                if (status.out_free) begin
                    cmd.out_op = OUT_CHAR;
                    if (status.idx_last) begin
                        cmd.cur_op   = CUR_ZERO;
                        cmd.len_op   = LEN_ZERO;
                        cmd.phase_wr = 1'b1;
                    end else begin
                        cmd.idx_op = IDX_INC;
                    end
                end
            end
            default: s_tready = 1'b0;
        endcase
    end

`ifndef SYNTHESIS
    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (state_reg == ST_IDLE))
        else $error("tle_ctrl: ready outside idle");

    a_accept_to_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_DECODE))
        else $error("tle_ctrl: accepted request not decoded");

    a_load_waits_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_op != OUT_NONE) |-> status.out_free)
        else $error("tle_ctrl: output loaded while occupied");
`endif

endmodule

`default_nettype wire

/* rtl/core/tle_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tle_dp: line editor datapath
// Line buffer memory, cursor/length/escape registers, config register and
// the output register slice.
// ----------------------------------------------------------------------------
`default_nettype none

module tle_dp
    import tle_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [CHAR_W-1:0]  s_tdata,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CFG_W-1:0]   cfg_data,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [15:0]             m_tdata,
    output logic                    m_tlast,
    output logic                    m_tuser,
    input  wire cmd_t               cmd,
    output status_t                 status
);

    logic [CHAR_W-1:0] mem [LINE_CAP];

    logic [CHAR_W-1:0] byte_reg;
    logic [CHAR_W-1:0] rd_data_reg;
    logic [LEN_W-1:0]  cursor_reg, cursor_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;
    phase_t            phase_reg;
    logic [CFG_W-1:0]  max_len_reg;

    logic              m_valid_reg;
    logic [CHAR_W-1:0] m_char_reg;
    logic [LEN_W-1:0]  m_len_reg;
    logic              m_last_reg;
    logic              m_empty_reg;

    logic [LEN_W-1:0]  idx_prev;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [CHAR_W-1:0] wr_data;
    logic              rd_en;
    logic              wr_en;
    kind_t             kind;
    logic              out_free;

    assign idx_prev = idx_reg - 1'b1;
    assign out_free = !m_valid_reg || m_tready;

    // byte classification
    always_comb begin
        unique case (byte_reg)
            KEY_RETURN:  kind = KIND_RETURN;
            KEY_DELETE:  kind = KIND_DELETE;
            KEY_ESCAPE:  kind = KIND_ESCAPE;
            KEY_HOME:    kind = KIND_HOME;
            KEY_BACK:    kind = KIND_BACK;
            KEY_END:     kind = KIND_END;
            KEY_FORWARD: kind = KIND_FORWARD;
            default: begin
                kind = (byte_reg >= KEY_PRINT_LOW && byte_reg < KEY_DELETE) ?
                       KIND_PRINT : KIND_OTHER;
            end
        endcase
    end

    always_comb begin
        status.phase      = phase_reg;
        status.kind       = kind;
        status.is_bracket = (byte_reg == KEY_BRACKET);
        status.is_left    = (byte_reg == KEY_LEFT);
        status.is_right   = (byte_reg == KEY_RIGHT);
        status.cur_gt0    = (cursor_reg != '0);
        status.cur_lt_len = (cursor_reg < len_reg);
        status.len_lt_max = ((LEN_W+1)'(len_reg) < (LEN_W+1)'(max_len_reg)) &&
                            ((LEN_W+1)'(len_reg) < (LEN_W+1)'(LINE_CAP));
        status.len_zero   = (len_reg == '0);
        status.idx_gt_cur = (idx_reg > cursor_reg);
        status.idx_lt_len = (idx_reg < len_reg);
        status.idx_last   = (((LEN_W+1)'(idx_reg) + 1'b1) == (LEN_W+1)'(len_reg));
        status.out_free   = out_free;
    end

    // memory port selection
    always_comb begin
        rd_en   = (cmd.rd_op != RD_NONE);
        rd_addr = (cmd.rd_op == RD_PREV) ? idx_prev[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];
        wr_en   = 1'b1;
        wr_addr = idx_reg[ADDR_W-1:0];
        wr_data = rd_data_reg;
        case (cmd.wr_op)
            WR_SHIFT_UP:   wr_addr = idx_reg[ADDR_W-1:0];
            WR_SHIFT_DOWN: wr_addr = idx_prev[ADDR_W-1:0];
            WR_BYTE: begin
                wr_addr = cursor_reg[ADDR_W-1:0];
                wr_data = byte_reg;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        case (cmd.cur_op)
            CUR_ZERO: cursor_next = '0;
            CUR_DEC:  cursor_next = cursor_reg - 1'b1;
            CUR_INC:  cursor_next = cursor_reg + 1'b1;
            CUR_END:  cursor_next = len_reg;
            default:  cursor_next = cursor_reg;
        endcase
        case (cmd.len_op)
            LEN_ZERO: len_next = '0;
            LEN_INC:  len_next = len_reg + 1'b1;
            LEN_DEC:  len_next = len_reg - 1'b1;
            default:  len_next = len_reg;
        endcase
        case (cmd.idx_op)
            IDX_LEN:  idx_next = len_reg;
            IDX_CUR:  idx_next = cursor_reg;
            IDX_ZERO: idx_next = '0;
            IDX_INC:  idx_next = idx_reg + 1'b1;
            IDX_DEC:  idx_next = idx_prev;
            default:  idx_next = idx_reg;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg  <= '0;
            len_reg     <= '0;
            phase_reg   <= PHASE_NORMAL;
            max_len_reg <= MAX_LEN_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            cursor_reg <= cursor_next;
            len_reg    <= len_next;
            if (cmd.phase_wr) phase_reg <= cmd.phase_val;
            if (cfg_valid) max_len_reg <= cfg_data;
            if (cmd.out_op != OUT_NONE) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (cmd.load_byte) byte_reg <= s_tdata;
        case (cmd.out_op)
            OUT_CHAR: begin
                m_char_reg  <= rd_data_reg;
                m_len_reg   <= len_reg;
                m_last_reg  <= status.idx_last;
                m_empty_reg <= 1'b0;
            end
            OUT_EMPTY: begin
                m_char_reg  <= '0;
                m_len_reg   <= '0;
                m_last_reg  <= 1'b1;
                m_empty_reg <= 1'b1;
            end
            default: m_char_reg <= m_char_reg;
        endcase
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(16 - CHAR_W - LEN_W){1'b0}}, m_len_reg, m_char_reg};
    assign m_tlast   = m_last_reg;
    assign m_tuser   = m_empty_reg;

`ifndef SYNTHESIS
    a_cursor_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_reg <= len_reg)
        else $error("tle_dp: cursor past end of line");

    a_len_in_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (LEN_W+1)'(len_reg) <= (LEN_W+1)'(LINE_CAP))
        else $error("tle_dp: line length above capacity");

    a_len_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (len_reg != $past(len_reg)) |->
            (len_reg == $past(len_reg) + 1'b1 || len_reg == $past(len_reg) - 1'b1 ||
             len_reg == '0))
        else $error("tle_dp: line length jumped");

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_empty_reg) |-> (m_last_reg && m_len_reg == '0))
        else $error("tle_dp: empty-line result malformed");
`endif

endmodule

`default_nettype wire

/* rtl/core/terminal_line_editor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_line_editor: emacs-style line editor for a terminal byte stream
// Keeps an editable line with a cursor and emits the finished line on return.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one received byte per request. Printable bytes insert at the
//   cursor, 0x7F deletes before it, Ctrl-A/E/B/F and ESC [ D / ESC [ C move
//   it, other escape sequences are dropped. Return sends the line on m_*,
//   one character per request (tlast on the final one), or a single request
//   with tuser set for an empty line, then clears the editor.
//   cfg_* writes max_length (reset 63); write it only while idle.
// Sequencing:
//   Each byte is accepted in idle and then decoded. Insert and delete
//   then move the characters between cursor and line end one at a time,
//   with a read state and a write state per character on the line buffer.
//   Return reads each character and loads it into the output register,
//   waiting while the output slot is still occupied.
// Reset clears cursor, length, escape state and the output valid; the
// buffer itself is not cleared. A stalled m_tready holds the result in the
// output register; readout pauses, and s_tready stays low until it is done.
// ----------------------------------------------------------------------------
`default_nettype none

module terminal_line_editor
    import tle_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input requests
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
    // max_length write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [5:0]  cfg_data,  // [5:0] max_length
    // result requests
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] line_char, [13:8] line_length
    output logic             m_tlast,   // last_of_line
    output logic             m_tuser    // empty_line
);

    cmd_t    cmd;      // controller -> datapath
    status_t status;   // datapath -> controller

    // sequencer: decode, shift loops, readout
    tle_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // buffer, cursor/length, config and output slice
    tle_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the terminal line editor
// Feeds terminal bytes on s_*, rebuilds the edited line in a local model of
// cursor, length, escape phase and buffer, and checks every character that
// comes out on m_* in order. A short table of hand-picked keys runs first,
// then random edit sessions under several max_length settings, with random
// back-pressure and gaps on both streams.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import tle_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 9;
    // worst case: an insert at home of a nearly full line
    localparam int DRAIN_CYCLES = 200;
    localparam int QUIET_LIMIT  = 2000;
    localparam int REPORT_MAX   = 10;
    localparam int DIR_N        = 25;
    localparam int PHASE_N      = 6;
    localparam int PHASE_BYTES  = 22;

    // one result request as the editor emits it
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic [LEN_W-1:0]  len;
        logic              last;
        logic              empty;
    } line_out_t;

    // directed key: result typed in by hand where typed is set
    typedef struct packed {
        logic [CHAR_W-1:0] key;
        logic              typed;
        line_out_t         res;
    } key_row_t;

    // ---------------------------------------------------------------- DUT I/O
    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [7:0]        s_tdata;    // [7:0] in_byte
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data;   // [5:0] max_length
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [15:0]       m_tdata;    // [7:0] line_char, [13:8] line_length
    logic              m_tlast;    // last_of_line
    logic              m_tuser;    // empty_line

    terminal_line_editor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ---------------------------------------------------- local editor model
    logic [CHAR_W-1:0] line_buf [0:LINE_CAP-1];
    logic [LEN_W-1:0]  cur_pos   = '0;
    logic [LEN_W-1:0]  line_len  = '0;
    phase_t            esc_phase = PHASE_NORMAL;
    logic [CFG_W-1:0]  max_len   = MAX_LEN_RESET;

    line_out_t pending_chars [$];   // characters still owed by the editor

    // run statistics and status
    int  fail_count   = 0;
    int  bytes_sent   = 0;
    int  lines_closed = 0;
    int  chars_seen   = 0;
    int  cfg_writes   = 0;
    int  quiet_cycles = 0;
    int  hold_cnt     = 0;
    bit  calm         = 1'b0;   // no idling on either side while set

    // Apply one key to the model; results go to pending_chars when keep is set.
    task automatic edit_line(input logic [CHAR_W-1:0] key, input bit keep);
        int        i;
        int        cap;
        line_out_t r;
        cap = (int'(max_len) < LINE_CAP) ? int'(max_len) : LINE_CAP;
        if (esc_phase == PHASE_ESC) begin
            // byte after ESC is always eaten; only '[' opens a direction
            esc_phase = (key == KEY_BRACKET) ? PHASE_BRACKET : PHASE_NORMAL;
        end else if (esc_phase == PHASE_BRACKET) begin
            if (key == KEY_LEFT && cur_pos > 0)
                cur_pos = cur_pos - 1'b1;
            else if (key == KEY_RIGHT && cur_pos < line_len)
                cur_pos = cur_pos + 1'b1;
            esc_phase = PHASE_NORMAL;
        end else if (key == KEY_RETURN) begin
            lines_closed++;
            if (line_len == 0) begin
                r = '{ch: '0, len: '0, last: 1'b1, empty: 1'b1};
                if (keep) pending_chars.push_back(r);
            end else begin
                for (i = 0; i < int'(line_len); i++) begin
                    r.ch    = line_buf[i];
                    r.len   = line_len;
                    r.last  = (i + 1 == int'(line_len));
                    r.empty = 1'b0;
                    if (keep) pending_chars.push_back(r);
                end
            end
            cur_pos   = '0;
            line_len  = '0;
            esc_phase = PHASE_NORMAL;
        end else if (key == KEY_DELETE) begin
            if (cur_pos > 0) begin
                for (i = int'(cur_pos); i < int'(line_len); i++)
                    line_buf[i-1] = line_buf[i];
                cur_pos  = cur_pos - 1'b1;
                line_len = line_len - 1'b1;
            end
        end else if (key == KEY_ESCAPE) begin
            esc_phase = PHASE_ESC;
        end else if (key == KEY_HOME) begin
            cur_pos = '0;
        end else if (key == KEY_BACK) begin
            if (cur_pos > 0) cur_pos = cur_pos - 1'b1;
        end else if (key == KEY_END) begin
            cur_pos = line_len;
        end else if (key == KEY_FORWARD) begin
            if (cur_pos < line_len) cur_pos = cur_pos + 1'b1;
        end else if (key >= KEY_PRINT_LOW && key < KEY_DELETE
                     && int'(line_len) < cap) begin
            // open a slot at the cursor, shifting the tail up by one
            for (i = int'(line_len); i > int'(cur_pos); i--)
                line_buf[i] = line_buf[i-1];
            line_buf[cur_pos] = key;
            line_len = line_len + 1'b1;
            cur_pos  = cur_pos + 1'b1;
        end
        // anything else (other controls, 0x80..0xFF) leaves the line alone
    endtask

    task automatic note_fail(input string what);
        fail_count++;
        if (fail_count <= REPORT_MAX) $display("[%0t] ERROR: %s", $realtime, what);
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------- request drivers
    // Offer one byte from the falling edge and hold it until accepted.
    task automatic send_key(input logic [CHAR_W-1:0] key, input bit keep);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        edit_line(key, keep);
        bytes_sent++;
    endtask

    // Optional idle time after a request; valid stays up when no gap is taken.
    task automatic sender_gap();
        int g;
        g = 0;
        if (!calm && $urandom_range(0, 2) == 0) g = pick_gap();
        if (g > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (g - 1) @(negedge aclk);
        end
    endtask

    task automatic type_key(input logic [CHAR_W-1:0] key);
        send_key(key, 1'b1);
        sender_gap();
    endtask

    // Stop sending and wait for the editor to drain and go idle.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_len(input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        max_len = val;
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // One edit session ending in return. Mostly inserts and cursor moves,
    // with some arrow sequences, broken escapes and raw noise mixed in.
    task automatic type_line(input int steps, input bit fill);
        int k;
        int pick;
        for (k = 0; k < steps; k++) begin
            pick = fill ? 0 : $urandom_range(0, 99);
            if (pick < 55) begin
                type_key(8'($urandom_range(32, 126)));
            end else if (pick < 63) begin
                type_key(KEY_DELETE);
            end else if (pick < 67) begin
                type_key(KEY_HOME);
            end else if (pick < 71) begin
                type_key(KEY_END);
            end else if (pick < 75) begin
                type_key(KEY_BACK);
            end else if (pick < 79) begin
                type_key(KEY_FORWARD);
            end else if (pick < 87) begin
                type_key(KEY_ESCAPE);
                type_key(KEY_BRACKET);
                type_key($urandom_range(0, 1) ? KEY_LEFT : KEY_RIGHT);
            end else if (pick < 91) begin
                // escape followed by a random byte: mostly a bad direction or bad second byte
                type_key(KEY_ESCAPE);
                if ($urandom_range(0, 1)) type_key(KEY_BRACKET);
                type_key(8'($urandom_range(0, 255)));
            end else begin
                type_key(8'($urandom_range(0, 255)));
            end
        end
        type_key(KEY_RETURN);
        // sometimes hold off until the whole line has been read out
        if (!calm && $urandom_range(0, 5) == 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            while (pending_chars.size() != 0) @(posedge aclk);
        end
    endtask

    // ------------------------------------------------------ result receiver
    // m_tready drops for random stretches, driven at the falling edge.
    always @(negedge aclk) begin
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            hold_cnt <= pick_gap() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest owed character.
    always @(posedge aclk) begin
        line_out_t got;
        line_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{ch: m_tdata[7:0], len: m_tdata[13:8], last: m_tlast, empty: m_tuser};
            chars_seen++;
            if (pending_chars.size() == 0) begin
                note_fail($sformatf("unexpected result char=%02h len=%0d last=%0b empty=%0b",
                                    got.ch, got.len, got.last, got.empty));
            end else begin
                want = pending_chars.pop_front();
                if (got.ch !== want.ch || got.len !== want.len
                    || got.last !== want.last || got.empty !== want.empty)
                    note_fail($sformatf(
                        "result mismatch: exp char=%02h len=%0d last=%0b empty=%0b, got char=%02h len=%0d last=%0b empty=%0b",
                        want.ch, want.len, want.last, want.empty,
                        got.ch, got.len, got.last, got.empty));
            end
        end
    end

    // ------------------------------------------------------------- watchdog
    // Counts cycles in which no request of any channel is accepted.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("[%0t] watchdog: no request accepted for %0d cycles", $realtime, QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // --------------------------------------------------------- main sequence
    initial begin
        key_row_t         dir_rows [0:DIR_N-1];
        logic [CFG_W-1:0] cfg_plan [0:PHASE_N-1];
        int               p;
        int               n;
        int               phase_stop;

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;

        // Hand-picked keys at reset max_length 63. Typed results: return on an
        // empty line right after reset, and a one-character line.
        dir_rows = '{
            '{KEY_RETURN,  1'b1, '{8'h00, 6'd0, 1'b1, 1'b1}},
            '{8'h41,       1'b0, '0},
            '{KEY_RETURN,  1'b1, '{8'h41, 6'd1, 1'b1, 1'b0}},
            '{8'h20,       1'b0, '0},   // lowest printable
            '{8'h7E,       1'b0, '0},   // highest printable
            '{KEY_HOME,    1'b0, '0},
            '{KEY_BACK,    1'b0, '0},   // step left at home: no move
            '{KEY_DELETE,  1'b0, '0},   // delete at home: no change
            '{KEY_FORWARD, 1'b0, '0},
            '{KEY_DELETE,  1'b0, '0},
            '{KEY_END,     1'b0, '0},
            '{KEY_FORWARD, 1'b0, '0},   // step right at end: no move
            '{KEY_ESCAPE,  1'b0, '0},
            '{KEY_BRACKET, 1'b0, '0},
            '{KEY_LEFT,    1'b0, '0},
            '{KEY_ESCAPE,  1'b0, '0},
            '{KEY_BRACKET, 1'b0, '0},
            '{KEY_RIGHT,   1'b0, '0},
            '{KEY_ESCAPE,  1'b0, '0},
            '{KEY_RETURN,  1'b0, '0},   // return right after ESC is eaten
            '{KEY_ESCAPE,  1'b0, '0},
            '{KEY_BRACKET, 1'b0, '0},
            '{KEY_RETURN,  1'b0, '0},   // return as direction is eaten too
            '{8'hFF,       1'b0, '0},   // high byte ignored
            '{KEY_RETURN,  1'b0, '0}
        };

        // max_length settings: small, one, zero (no inserts), full, mid, random
        cfg_plan = '{6'd3, 6'd1, 6'd0, 6'd63, 6'd40, 6'd0};
        cfg_plan[PHASE_N-1] = 6'($urandom_range(2, 62));

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (n = 0; n < DIR_N; n++) begin
            send_key(dir_rows[n].key, !dir_rows[n].typed);
            if (dir_rows[n].typed) pending_chars.push_back(dir_rows[n].res);
            sender_gap();
        end

        // random sessions, one max_length setting per phase
        for (p = 0; p < PHASE_N; p++) begin
            settle();
            write_max_len(cfg_plan[p]);
            calm = ($urandom_range(0, 3) == 0);
            phase_stop = bytes_sent + PHASE_BYTES;
            // at full length, push one line past its limit
            if (cfg_plan[p] == 6'd63) type_line(LINE_CAP + 2, 1'b1);
            while (bytes_sent < phase_stop) begin
                if ($urandom_range(0, 9) == 0)
                    type_line(0, 1'b0);
                else
                    type_line($urandom_range(1, 12), 1'b0);
            end
        end

        calm = 1'b0;
        settle();
        if (pending_chars.size() != 0)
            note_fail($sformatf("%0d results never arrived", pending_chars.size()));

        $display("Run covered %0d input bytes, %0d returned lines, %0d result characters",
                 bytes_sent, lines_closed, chars_seen);
        $display("max_length written %0d times (0, 1, 3, 40, 63 and one random value)",
                 cfg_writes);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d errors", fail_count);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
